// ===== rtl/core/bfp_pkg.sv =====
`default_nettype none

package bfp_pkg;

  // Frame length bound; bytes at or past it are dropped
  localparam int unsigned MaxFrameBytes = 4096;
  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

  // Byte offsets in the frame
  localparam int unsigned PosBssid0   = 16;
  localparam int unsigned PosBssid2   = 18;
  localparam int unsigned PosSeqLo    = 22;
  localparam int unsigned PosSeqHi    = 23;
  localparam int unsigned PosTsFirst  = 24;
  localparam int unsigned PosFixFirst = 32;
  localparam int unsigned PosWalk     = 36;

  // Element walk phases
  localparam logic [1:0] PhTag  = 2'd0;
  localparam logic [1:0] PhLen  = 2'd1;
  localparam logic [1:0] PhData = 2'd2;
  localparam logic [1:0] PhStop = 2'd3;

  // Security kinds
  localparam logic [1:0] SecOpen = 2'd0;
  localparam logic [1:0] SecWpa  = 2'd1;
  localparam logic [1:0] SecWpa2 = 2'd2;
  localparam logic [1:0] SecWpa3 = 2'd3;

  localparam logic [7:0]  TagRsn    = 8'd48;
  localparam logic [7:0]  TagVendor = 8'd221;
  localparam logic [23:0] WpaOui    = 24'h0050F2;
  localparam logic [7:0]  WpaType   = 8'h01;
  localparam logic [23:0] SaePrefix = 24'h000FAC;
  localparam logic [7:0]  SaeLast   = 8'h08;
  localparam logic [7:0]  RsnMinLen = 8'd2;
  localparam logic [7:0]  SaeMinLen = 8'd14;
  localparam logic [7:0]  VndMinLen = 8'd4;

  localparam int unsigned NumGroups = 6;
  localparam int unsigned OuisPerGroup = 3;

  localparam logic [23:0] VendorGroups [NumGroups][OuisPerGroup] = '{
    '{24'h001018, 24'h7C5049, 24'h001CB3},
    '{24'hB0C090, 24'hF46D04, 24'hB0C090},
    '{24'hDC9FDB, 24'h0023DF, 24'hDC9FDB},
    '{24'h001DD8, 24'h001E52, 24'h001DD8},
    '{24'h0050F2, 24'h0050F2, 24'h0050F2},
    '{24'h8C8590, 24'h001FF3, 24'h8C8590}
  };

  // 0 unknown, else group number from 1; earliest group wins
  function automatic logic [2:0] classify_oui(input logic [23:0] oui);
    logic [2:0] cls;
    cls = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      for (int k = 0; k < OuisPerGroup; k++) begin
        if (VendorGroups[g][k] == oui) begin
          cls = 3'(g + 1);
        end
      end
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfp_intf.sv =====
`default_nettype none

interface bfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface bfp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] timestamp_value;
  logic [15:0] interval_tu;
  logic [15:0] capability_word;
  logic [11:0] sequence_number;
  logic [3:0]  fragment_number;
  logic [23:0] bssid_oui;
  logic [2:0]  oui_vendor_class;
  logic [1:0]  security_kind;
  logic        vendor_element_seen;
  logic [23:0] vendor_element_oui;
  logic [7:0]  vendor_element_type;
  logic        frame_too_short;

  modport source (
    output valid, input ready,
    output timestamp_value, output interval_tu, output capability_word,
    output sequence_number, output fragment_number, output bssid_oui,
    output oui_vendor_class, output security_kind, output vendor_element_seen,
    output vendor_element_oui, output vendor_element_type, output frame_too_short
  );
  modport sink (
    input valid, output ready,
    input timestamp_value, input interval_tu, input capability_word,
    input sequence_number, input fragment_number, input bssid_oui,
    input oui_vendor_class, input security_kind, input vendor_element_seen,
    input vendor_element_oui, input vendor_element_type, input frame_too_short
  );
endinterface

`default_nettype wire

// ===== rtl/core/beacon_frame_ie_parser.sv =====
`default_nettype none

// Beacon frame parser. Takes a beacon one byte per transaction from the first
// MAC header byte; end_of_frame marks the last byte, and exactly one summary
// transaction comes out per frame. Sustained rate is one byte per cycle: a
// byte sits in an input register, then one pass of compare/capture logic
// updates the frame state and, on the last byte, loads the output register.
// The only stall is a frame's last byte meeting a summary that has not yet
// been taken downstream. Captures: BSSID OUI and vendor class,
// sequence/fragment numbers, timestamp, interval, capability word. From byte
// 36 on the tag-length elements are walked: a zero length stops the walk, an
// element cut short by frame end (or by the 4096-byte bound) has no effect,
// the first complete RSN element of 2 or more bytes gives WPA2, or WPA3 with
// SAE suite 00-0F-AC-08 wholly inside and 14 or more bytes, and the first
// vendor element with the WPA OUI and type 1 gives WPA when no RSN came first.
// All frame state clears after each summary; no clearing pass is needed.
module beacon_frame_ie_parser
  import bfp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bfp_in_if.sink     byte_i,
  bfp_out_if.source  result_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eof_q;
  logic       step;

  // Frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  bie_q, bie_d;
  logic [23:0] win_q, win_d;
  logic        sae_q, sae_d;
  logic [1:0]  seen_q, seen_d;       // bit 0 RSN taken, bit 1 vendor taken
  logic [1:0]  sec_q, sec_d;
  logic [15:0] seq_q, seq_d;
  logic [23:0] oui_q, oui_d;
  logic [63:0] ts_q, ts_d;
  logic [15:0] ival_q, ival_d;
  logic [15:0] cap_q, cap_d;
  logic [31:0] vcap_q, vcap_d;       // OUI in 31..8, type in 7..0
  logic        vseen_q, vseen_d;

  // Output register
  logic        res_valid_q;
  logic [63:0] res_ts_q;
  logic [15:0] res_ival_q;
  logic [15:0] res_cap_q;
  logic [15:0] res_seq_q;
  logic [23:0] res_oui_q;
  logic [2:0]  res_cls_q;
  logic [1:0]  res_sec_q;
  logic        res_vseen_q;
  logic [31:0] res_vcap_q;
  logic        res_short_q;

  // A last byte waits only while the output register is occupied and not being taken
  assign step = s1_valid_q && !(s1_eof_q && res_valid_q && !result_o.ready);
  assign byte_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      s1_byte_q <= byte_i.frame_byte;
      s1_eof_q  <= byte_i.end_of_frame;
    end
  end

  // One byte's worth of state update
  always_comb begin
    logic [7:0] b;
    logic [7:0] j_nx;
    logic       rsn_open;
    logic       vnd_open;
    b = s1_byte_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    tag_d   = tag_q;
    len_d   = len_q;
    bie_d   = bie_q;
    win_d   = win_q;
    sae_d   = sae_q;
    seen_d  = seen_q;
    sec_d   = sec_q;
    seq_d   = seq_q;
    oui_d   = oui_q;
    ts_d    = ts_q;
    ival_d  = ival_q;
    cap_d   = cap_q;
    vcap_d  = vcap_q;
    vseen_d = vseen_q;
    j_nx     = bie_q + 8'd1;
    rsn_open = (tag_q == TagRsn) && !seen_q[0];
    vnd_open = (tag_q == TagVendor) && !seen_q[1];

    if (step && (pos_q < PosW'(MaxFrameBytes))) begin
      pos_d = pos_q + PosW'(1);
      if (pos_q < PosW'(PosTsFirst)) begin
        if (pos_q >= PosW'(PosBssid0) && pos_q <= PosW'(PosBssid2)) begin
          oui_d[8*(PosBssid2 - 32'(pos_q)) +: 8] = b;
        end else if (pos_q == PosW'(PosSeqLo)) begin
          seq_d[7:0] = b;
        end else if (pos_q == PosW'(PosSeqHi)) begin
          seq_d[15:8] = b;
        end
      end else if (pos_q < PosW'(PosFixFirst)) begin
        ts_d[8*pos_q[2:0] +: 8] = b;       // offset 24 is a multiple of 8
      end else if (pos_q < PosW'(PosWalk)) begin
        case (pos_q[1:0])
          2'd0:    ival_d[7:0]  = b;
          2'd1:    ival_d[15:8] = b;
          2'd2:    cap_d[7:0]   = b;
          default: cap_d[15:8]  = b;
        endcase
      end else begin
        case (phase_q)
          PhTag: begin
            tag_d   = b;
            phase_d = PhLen;
          end
          PhLen: begin
            if (b == 8'd0) begin
              phase_d = PhStop;
            end else begin
              len_d   = b;
              bie_d   = 8'd0;
              win_d   = 24'd0;
              sae_d   = 1'b0;
              phase_d = PhData;
            end
          end
          PhData: begin
            if (rsn_open) begin
              if (bie_q >= 8'd3 && win_q == SaePrefix && b == SaeLast) begin
                sae_d = 1'b1;
              end
              win_d = {win_q[15:0], b};
            end else if (vnd_open && bie_q < 8'd4) begin
              vcap_d[8*(2'd3 - bie_q[1:0]) +: 8] = b;
            end
            bie_d = j_nx;
            if (j_nx == len_q) begin
              phase_d = PhTag;
              if (rsn_open) begin
                seen_d[0] = 1'b1;
                if (len_q >= RsnMinLen) begin
                  sec_d = (len_q >= SaeMinLen && sae_d) ? SecWpa3 : SecWpa2;
                end
              end else if (vnd_open) begin
                seen_d[1] = 1'b1;
                if (len_q >= VndMinLen) begin
                  vseen_d = 1'b1;
                  if (vcap_d[31:8] == WpaOui && vcap_d[7:0] == WpaType && !seen_q[0]) begin
                    sec_d = SecWpa;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Frame state clears after the summary is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PhTag;
      tag_q   <= '0;
      len_q   <= '0;
      bie_q   <= '0;
      win_q   <= '0;
      sae_q   <= 1'b0;
      seen_q  <= '0;
      sec_q   <= SecOpen;
      seq_q   <= '0;
      oui_q   <= '0;
      ts_q    <= '0;
      ival_q  <= '0;
      cap_q   <= '0;
      vcap_q  <= '0;
      vseen_q <= 1'b0;
    end else if (step && s1_eof_q) begin
      pos_q   <= '0;
      phase_q <= PhTag;
      tag_q   <= '0;
      len_q   <= '0;
      bie_q   <= '0;
      win_q   <= '0;
      sae_q   <= 1'b0;
      seen_q  <= '0;
      sec_q   <= SecOpen;
      seq_q   <= '0;
      oui_q   <= '0;
      ts_q    <= '0;
      ival_q  <= '0;
      cap_q   <= '0;
      vcap_q  <= '0;
      vseen_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      bie_q   <= bie_d;
      win_q   <= win_d;
      sae_q   <= sae_d;
      seen_q  <= seen_d;
      sec_q   <= sec_d;
      seq_q   <= seq_d;
      oui_q   <= oui_d;
      ts_q    <= ts_d;
      ival_q  <= ival_d;
      cap_q   <= cap_d;
      vcap_q  <= vcap_d;
      vseen_q <= vseen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step && s1_eof_q) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && s1_eof_q) begin
      res_ts_q    <= ts_d;
      res_ival_q  <= ival_d;
      res_cap_q   <= cap_d;
      res_seq_q   <= seq_d;
      res_oui_q   <= oui_d;
      res_cls_q   <= classify_oui(oui_d);
      res_sec_q   <= sec_d;
      res_vseen_q <= vseen_d;
      res_vcap_q  <= vseen_d ? vcap_d : 32'd0;
      res_short_q <= (pos_d < PosW'(PosWalk));
    end
  end

  assign result_o.valid               = res_valid_q;
  assign result_o.timestamp_value     = res_ts_q;
  assign result_o.interval_tu         = res_ival_q;
  assign result_o.capability_word     = res_cap_q;
  assign result_o.sequence_number     = res_seq_q[15:4];
  assign result_o.fragment_number     = res_seq_q[3:0];
  assign result_o.bssid_oui           = res_oui_q;
  assign result_o.oui_vendor_class    = res_cls_q;
  assign result_o.security_kind       = res_sec_q;
  assign result_o.vendor_element_seen = res_vseen_q;
  assign result_o.vendor_element_oui  = res_vcap_q[31:8];
  assign result_o.vendor_element_type = res_vcap_q[7:0];

  assign result_o.frame_too_short     = res_short_q;

  // A stopped walk stays stopped until the frame ends
  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhStop && !(step && s1_eof_q)) |=> (phase_q == PhStop))
    else $error("element walk left the stopped phase mid-frame");

  // Each summary restarts the byte count
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && s1_eof_q) |=> (pos_q == '0 && res_valid_q))
    else $error("frame state not cleared after summary");

  // Any security kind other than open needs a taken RSN or vendor element
  a_sec_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_q != SecOpen) |-> (seen_q != 2'b00))
    else $error("security kind set without a taken element");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  import bfp_pkg::*;

  // Everything the parser reports for one frame, in output-port order
  typedef struct packed {
    logic [63:0] timestamp_value;
    logic [15:0] interval_tu;
    logic [15:0] capability_word;
    logic [11:0] sequence_number;
    logic [3:0]  fragment_number;
    logic [23:0] bssid_oui;
    logic [2:0]  oui_vendor_class;
    logic [1:0]  security_kind;
    logic        vendor_element_seen;
    logic [23:0] vendor_element_oui;
    logic [7:0]  vendor_element_type;
    logic        frame_too_short;
  } summary_t;

  // Shapes of the hand-written frames
  typedef enum logic [2:0] {
    DkFill,   // a bytes, every one equal to b
    DkRsn,    // RSN element of length a, SAE suite placed at data offset b
    DkVnd,    // vendor element of length a and type b, arranged per mode c
    DkZero,   // zero-length tag ahead of RSN and vendor WPA elements
    DkCut,    // element with tag a cut short by the end of the frame
    DkOui     // BSSID taken from vendor group a, entry b
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e   kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic        typed;  // use the summary below rather than the predictor's
    summary_t    want;
  } dir_row_t;

  // Vendor row arrangements
  localparam logic [15:0] VmWpaOnly  = 16'd0;
  localparam logic [15:0] VmRsnFirst = 16'd1;
  localparam logic [15:0] VmRsnAfter = 16'd2;
  localparam logic [15:0] VmOtherOui = 16'd3;

  localparam int NoSae      = 65535;  // SAE offset past any element: no pattern
  localparam int StallLimit = 2000;   // cycles without any transaction
  localparam int RandFrames = 12;     // three frames in each idling phase

  // Summaries that can be read straight off the frame layout
  localparam summary_t SumOneByte = '{frame_too_short: 1'b1, default: '0};
  localparam summary_t SumShortOnes = '{
    timestamp_value: '1, interval_tu: '1, capability_word: 16'h00FF,
    sequence_number: '1, fragment_number: '1, bssid_oui: '1,
    frame_too_short: 1'b1, default: '0
  };
  localparam summary_t SumFullOnes = '{
    timestamp_value: '1, interval_tu: '1, capability_word: '1,
    sequence_number: '1, fragment_number: '1, bssid_oui: '1, default: '0
  };

  dir_row_t dir_tab [24] = '{
    // short and fixed-part-only frames at both byte extremes
    '{DkFill, 16'd1,  16'h00, 16'd0, 1'b1, SumOneByte},
    '{DkFill, 16'd35, 16'hFF, 16'd0, 1'b1, SumShortOnes},
    '{DkFill, 16'd36, 16'h00, 16'd0, 1'b1, summary_t'('0)},
    '{DkFill, 16'd36, 16'hFF, 16'd0, 1'b1, SumFullOnes},
    // walk starts: tag FF length FF never completes, so nothing changes
    '{DkFill, 16'd64, 16'hFF, 16'd0, 1'b1, SumFullOnes},
    // RSN: too short for a suite, WPA2, SAE at both ends, SAE in a short one,
    // SAE hanging over the end, SAE in the middle of a long one
    '{DkRsn, 16'd1,  16'(NoSae), 16'd0, 1'b0, summary_t'('0)},
    '{DkRsn, 16'd2,  16'(NoSae), 16'd0, 1'b0, summary_t'('0)},
    '{DkRsn, 16'd14, 16'd0,      16'd0, 1'b0, summary_t'('0)},
    '{DkRsn, 16'd14, 16'd10,     16'd0, 1'b0, summary_t'('0)},
    '{DkRsn, 16'd13, 16'd9,      16'd0, 1'b0, summary_t'('0)},
    '{DkRsn, 16'd20, 16'd17,     16'd0, 1'b0, summary_t'('0)},
    '{DkRsn, 16'd30, 16'd5,      16'd0, 1'b0, summary_t'('0)},
    // vendor elements: WPA, too short, after and before RSN, other type/OUI
    '{DkVnd, 16'd4, 16'd1, VmWpaOnly,  1'b0, summary_t'('0)},
    '{DkVnd, 16'd3, 16'd1, VmWpaOnly,  1'b0, summary_t'('0)},
    '{DkVnd, 16'd8, 16'd1, VmRsnFirst, 1'b0, summary_t'('0)},
    '{DkVnd, 16'd6, 16'd1, VmRsnAfter, 1'b0, summary_t'('0)},
    '{DkVnd, 16'd5, 16'd2, VmWpaOnly,  1'b0, summary_t'('0)},
    '{DkVnd, 16'd9, 16'd1, VmOtherOui, 1'b0, summary_t'('0)},
    '{DkZero, 16'd0, 16'd0, 16'd0, 1'b0, summary_t'('0)},
    '{DkCut, 16'(TagRsn),    16'd0, 16'd0, 1'b0, summary_t'('0)},
    '{DkCut, 16'(TagVendor), 16'd0, 16'd0, 1'b0, summary_t'('0)},
    '{DkOui, 16'd5, 16'd1, 16'd0, 1'b0, summary_t'('0)},
    '{DkOui, 16'd1, 16'd1, 16'd0, 1'b0, summary_t'('0)},
    '{DkOui, 16'd4, 16'd0, 16'd0, 1'b0, summary_t'('0)}
  };

  logic clk_i;
  logic rst_ni;
  logic sink_rdy = 1'b0;

  bfp_in_if  byte_if ();
  bfp_out_if sum_if ();

  assign sum_if.ready = sink_rdy;

  beacon_frame_ie_parser u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (sum_if)
  );

  // Low phase first so the first rising edge falls at 4
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: its own copy of the per-frame state
  // ---------------------------------------------------------------------------
  int unsigned pos_cnt;     // bytes taken, held at the length bound
  logic [1:0]  walk_ph;     // element walk phase
  logic [7:0]  el_tag;
  logic [7:0]  el_len;
  logic [7:0]  el_idx;      // data bytes seen in the current element
  logic [23:0] rsn_win;     // last three RSN data bytes
  logic        sae_found;
  logic        rsn_done;    // first RSN element consumed
  logic        vnd_done;    // first vendor element consumed
  logic        vnd_ok;      // ... and it was long enough to report
  logic [1:0]  sec_kind;
  logic [15:0] seq_ctl;
  logic [23:0] bssid_hi;
  logic [63:0] tsf_word;
  logic [15:0] ivl_word;
  logic [15:0] cap_word;
  logic [31:0] vnd_word;    // OUI in 31..8, type in 7..0

  summary_t pending_summaries [$];
  logic [7:0] frame_q [$];

  int fail_cnt = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int idle_cycles = 0;

  function automatic void clear_parser();
    pos_cnt   = 0;
    walk_ph   = PhTag;
    el_tag    = '0;
    el_len    = '0;
    el_idx    = '0;
    rsn_win   = '0;
    sae_found = 1'b0;
    rsn_done  = 1'b0;
    vnd_done  = 1'b0;
    vnd_ok    = 1'b0;
    sec_kind  = SecOpen;
    seq_ctl   = '0;
    bssid_hi  = '0;
    tsf_word  = '0;
    ivl_word  = '0;
    cap_word  = '0;
    vnd_word  = '0;
  endfunction

  // Takes one byte; returns 1 with the frame summary on the last byte
  function automatic bit parse_byte(input logic [7:0] b, input logic eof,
                                    output summary_t s);
    int unsigned p;
    logic [2:0]  cls;
    p = pos_cnt;
    s = '0;
    if (p < MaxFrameBytes) begin
      pos_cnt = p + 1;
      if (p >= PosBssid0 && p <= PosBssid2) begin
        bssid_hi[8*(PosBssid2-p) +: 8] = b;
      end else if (p == PosSeqLo) begin
        seq_ctl[7:0] = b;
      end else if (p == PosSeqHi) begin
        seq_ctl[15:8] = b;
      end else if (p >= PosTsFirst && p < PosFixFirst) begin
        tsf_word[8*(p-PosTsFirst) +: 8] = b;
      end else if (p >= PosFixFirst && p < PosFixFirst + 2) begin
        ivl_word[8*(p-PosFixFirst) +: 8] = b;
      end else if (p >= PosFixFirst + 2 && p < PosWalk) begin
        cap_word[8*(p-PosFixFirst-2) +: 8] = b;
      end else if (p >= PosWalk) begin
        case (walk_ph)
          PhTag: begin
            el_tag  = b;
            walk_ph = PhLen;
          end
          PhLen: begin
            if (b == 8'd0) begin
              walk_ph = PhStop;   // zero length ends the walk for good
            end else begin
              el_len    = b;
              el_idx    = '0;
              rsn_win   = '0;
              sae_found = 1'b0;
              walk_ph   = PhData;
            end
          end
          PhData: begin
            if (el_tag == TagRsn && !rsn_done) begin
              if (el_idx >= 8'd3 && rsn_win == SaePrefix && b == SaeLast) begin
                sae_found = 1'b1;
              end
              rsn_win = {rsn_win[15:0], b};
            end else if (el_tag == TagVendor && !vnd_done && el_idx < 8'd4) begin
              vnd_word = vnd_word | (32'(b) << (8 * (3 - int'(el_idx))));
            end
            el_idx = el_idx + 8'd1;
            if (el_idx == el_len) begin
              // element complete: only now does it count
              if (el_tag == TagRsn && !rsn_done) begin
                rsn_done = 1'b1;
                if (el_len >= RsnMinLen) begin
                  sec_kind = (el_len >= SaeMinLen && sae_found) ? SecWpa3 : SecWpa2;
                end
              end else if (el_tag == TagVendor && !vnd_done) begin
                vnd_done = 1'b1;
                if (el_len >= VndMinLen) begin
                  vnd_ok = 1'b1;
                  if (vnd_word[31:8] == WpaOui && vnd_word[7:0] == WpaType &&
                      !rsn_done) begin
                    sec_kind = SecWpa;
                  end
                end
              end
              walk_ph = PhTag;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (!eof) begin
      return 1'b0;
    end
    // earliest vendor group holding the OUI wins
    cls = '0;
    for (int g = 0; g < NumGroups; g++) begin
      for (int k = 0; k < OuisPerGroup; k++) begin
        if (cls == 3'd0 && VendorGroups[g][k] == bssid_hi) begin
          cls = 3'(g + 1);
        end
      end
    end
    s.timestamp_value     = tsf_word;
    s.interval_tu         = ivl_word;
    s.capability_word     = cap_word;
    s.sequence_number     = seq_ctl[15:4];
    s.fragment_number     = seq_ctl[3:0];
    s.bssid_oui           = bssid_hi;
    s.oui_vendor_class    = cls;
    s.security_kind       = sec_kind;
    s.vendor_element_seen = vnd_ok;
    s.vendor_element_oui  = vnd_ok ? vnd_word[31:8] : 24'd0;
    s.vendor_element_type = vnd_ok ? vnd_word[7:0] : 8'd0;
    s.frame_too_short     = (pos_cnt < PosWalk);
    clear_parser();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------
  // 36 random header and fixed-field bytes, optionally with a chosen BSSID OUI
  task automatic add_header(input logic [23:0] oui, input bit use_oui);
    repeat (PosWalk) frame_q.push_back(8'($urandom));
    if (use_oui) begin
      for (int i = 0; i < 3; i++) frame_q[PosBssid0 + i] = oui[23-8*i -: 8];
    end
  endtask

  // Element with random data; SAE suite bytes that fall inside are overlaid
  task automatic add_element(input logic [7:0] tag, input int len, input int sae_at);
    logic [31:0] pat;
    int          base;
    pat = {SaePrefix, SaeLast};
    frame_q.push_back(tag);
    frame_q.push_back(8'(len));
    base = frame_q.size();
    repeat (len) frame_q.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) begin
      if (sae_at + i < len) frame_q[base + sae_at + i] = pat[31-8*i -: 8];
    end
  endtask

  task automatic add_vendor(input logic [23:0] oui, input logic [7:0] vtype,
                            input int len);
    logic [31:0] body;
    body = {oui, vtype};
    frame_q.push_back(TagVendor);
    frame_q.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      frame_q.push_back((i < 4) ? body[31-8*i -: 8] : 8'($urandom));
    end
  endtask

  // Mostly well-formed beacons with random elements; some short or cut frames
  task automatic build_random_frame();
    int          pick;
    int          len;
    logic [23:0] oui;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, PosWalk - 1)) frame_q.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(99) < 40) begin
      add_header(VendorGroups[$urandom_range(NumGroups - 1)]
                             [$urandom_range(OuisPerGroup - 1)], 1'b1);
    end else begin
      add_header('0, 1'b0);
    end
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        case ($urandom_range(3))
          0:       len = $urandom_range(1, 2);
          1:       len = $urandom_range(13, 14);
          default: len = $urandom_range(3, 24);
        endcase
        add_element(TagRsn, len,
                    ($urandom_range(99) < 55) ? int'($urandom_range(0, len)) : NoSae);
      end else if (pick < 55) begin
        oui = ($urandom_range(99) < 65) ? WpaOui : 24'($urandom);
        add_vendor(oui, ($urandom_range(99) < 70) ? WpaType : 8'($urandom),
                   $urandom_range(1, 9));
      end else if (pick < 85) begin
        add_element(8'($urandom), $urandom_range(1, 12), NoSae);
      end else if (pick < 93) begin
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'h00);
      end else begin
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end
    end
    // chop the tail now and then so the last element is left open
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 6)) begin
        if (frame_q.size() > 1) void'(frame_q.pop_back());
      end
    end
  endtask

  // Sends the built frame byte by byte; each accepted byte goes to the
  // predictor straight after the edge that took it
  task automatic send_frame(input bit use_typed, input summary_t typed_res);
    summary_t got;
    logic     last;
    foreach (frame_q[i]) begin
      last = (i == frame_q.size() - 1);
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
        byte_if.valid <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
      end
      byte_if.valid        <= 1'b1;
      byte_if.frame_byte   <= frame_q[i];
      byte_if.end_of_frame <= last;
      do @(posedge clk_i); while (!byte_if.ready);
      if (parse_byte(frame_q[i], last, got)) begin
        pending_summaries.push_back(use_typed ? typed_res : got);
      end
    end
    frame_q.delete();
  endtask

  // Drop valid and hold off until every outstanding summary is back
  task automatic drain_summaries();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_summaries.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, checking, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sink_rdy <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    summary_t want;
    if (rst_ni && sum_if.valid && sum_if.ready) begin
      if (pending_summaries.size() == 0) begin
        $error("summary transaction with none outstanding");
        fail_cnt++;
      end else begin
        want = pending_summaries.pop_front();
        check_field("timestamp_value", want.timestamp_value, sum_if.timestamp_value);
        check_field("interval_tu", 64'(want.interval_tu), 64'(sum_if.interval_tu));
        check_field("capability_word", 64'(want.capability_word),
                    64'(sum_if.capability_word));
        check_field("sequence_number", 64'(want.sequence_number),
                    64'(sum_if.sequence_number));
        check_field("fragment_number", 64'(want.fragment_number),
                    64'(sum_if.fragment_number));
        check_field("bssid_oui", 64'(want.bssid_oui), 64'(sum_if.bssid_oui));
        check_field("oui_vendor_class", 64'(want.oui_vendor_class),
                    64'(sum_if.oui_vendor_class));
        check_field("security_kind", 64'(want.security_kind),
                    64'(sum_if.security_kind));
        check_field("vendor_element_seen", 64'(want.vendor_element_seen),
                    64'(sum_if.vendor_element_seen));
        check_field("vendor_element_oui", 64'(want.vendor_element_oui),
                    64'(sum_if.vendor_element_oui));
        check_field("vendor_element_type", 64'(want.vendor_element_type),
                    64'(sum_if.vendor_element_type));
        check_field("frame_too_short", 64'(want.frame_too_short),
                    64'(sum_if.frame_too_short));
      end
    end
  end

  // Any transaction on either side resets the count
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (sum_if.valid && sum_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[beacon_frame_ie_parser] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    int       rnd_frames;
    byte_if.valid        = 1'b0;
    byte_if.frame_byte   = '0;
    byte_if.end_of_frame = 1'b0;
    rst_ni               = 1'b0;
    rnd_frames           = 0;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames, no idling on either side
    foreach (dir_tab[r]) begin
      row = dir_tab[r];
      case (row.kind)
        DkFill: begin
          repeat (row.a) frame_q.push_back(row.b[7:0]);
        end
        DkRsn: begin
          add_header('0, 1'b0);
          add_element(TagRsn, int'(row.a), int'(row.b));
          add_element(8'd3, 1, NoSae);    // trailing DS element
        end
        DkVnd: begin
          add_header('0, 1'b0);
          if (row.c == VmRsnFirst) add_element(TagRsn, 2, NoSae);
          add_vendor((row.c == VmOtherOui) ? 24'($urandom) : WpaOui, row.b[7:0],
                     int'(row.a));
          if (row.c == VmRsnAfter) add_element(TagRsn, 2, NoSae);
        end
        DkZero: begin
          // everything after the zero-length tag is dead
          add_header('0, 1'b0);
          frame_q.push_back(8'd0);
          frame_q.push_back(8'd0);
          add_element(TagRsn, 2, NoSae);
          add_vendor(WpaOui, WpaType, 4);
        end
        DkCut: begin
          add_header('0, 1'b0);
          if (row.a[7:0] == TagRsn) add_element(TagRsn, 20, 0);
          else add_vendor(WpaOui, WpaType, 20);
          repeat (10) void'(frame_q.pop_back());
        end
        DkOui: begin
          add_header(VendorGroups[row.a[2:0]][row.b[1:0]], 1'b1);
          add_element(8'd0, 4, NoSae);    // SSID
        end
        default: begin
        end
      endcase
      send_frame(row.typed, row.want);
    end

    // Random frames in blocks of three, stepping through the idling phases;
    // every block starts with the sender held off until all summaries are in
    while (rnd_frames < RandFrames) begin
      if (rnd_frames % 3 == 0) begin
        drain_summaries();
        case ((rnd_frames / 3) % 4)
          0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
          default: begin src_idle_pct = 18; sink_stall_pct = 18; end
        endcase
      end
      build_random_frame();
      send_frame(1'b0, '0);
      rnd_frames++;
    end

    drain_summaries();
    repeat (8) @(posedge clk_i);   // room for any stray summary to show up
    if (fail_cnt == 0) begin
      $display("[beacon_frame_ie_parser] OK");
    end else begin
      $display("[beacon_frame_ie_parser] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
